### sv/ntle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntle_pkg: neighbor table shared types and constants
// Command and outcome codes, entry record and channel payload types.
// ----------------------------------------------------------------------------
package ntle_pkg;

  localparam int unsigned DEFAULT_SLOTS = 32;
  localparam logic [31:0] TTL_RESET     = 32'd600000;

  localparam logic [1:0] CMD_HEARD = 2'd0;
  localparam logic [1:0] CMD_TOUCH = 2'd1;

  localparam logic [1:0] OUT_FOUND    = 2'd0;
  localparam logic [1:0] OUT_INSERTED = 2'd1;
  localparam logic [1:0] OUT_EVICTED  = 2'd2;
  localparam logic [1:0] OUT_PRUNED   = 2'd3;

  typedef struct packed {
    logic [15:0] address;
    logic [31:0] last_heard;
    logic [15:0] strength;
    logic [7:0]  noise_ratio;
    logic [31:0] packets;
  } entry_t;

  typedef struct packed {
    logic        [1:0]  command;
    logic        [15:0] node_address;
    logic signed [15:0] signal_strength;
    logic signed [7:0]  signal_to_noise;
    logic        [31:0] time_now;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [7:0]  slot_index;
    logic [15:0] evicted_address;
    logic [31:0] packet_count;
    logic [31:0] last_heard_time;
    logic [8:0]  removed_count;
    logic [8:0]  entries_in_use;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_PRUNE,
    ST_DONE
  } state_t;

endpackage

### sv/ntle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntle_in_if / ntle_out_if / ntle_cfg_if: valid-ready channels
// One interface per channel payload type.
// ----------------------------------------------------------------------------
interface ntle_in_if;
  logic               valid;
  logic               ready;
  ntle_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ntle_out_if;
  logic                valid;
  logic                ready;
  ntle_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ntle_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/ntle_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntle_cell: one table slot in the rotating chain
// Holds one entry; on a shift loads from its neighbor, or from the tail
// input when it is the last cell of the active window.
// ----------------------------------------------------------------------------
module ntle_cell (
  input  logic             clk,
  input  logic             shift,
  input  logic             take_tail,
  input  ntle_pkg::entry_t prev_entry,
  input  ntle_pkg::entry_t tail_entry,
  output ntle_pkg::entry_t entry
);

  ntle_pkg::entry_t entry_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      entry_r <= take_tail ? tail_entry : prev_entry;
    end
  end

  assign entry = entry_r;

endmodule

### sv/neighbor_table_lru_evict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_table_lru_evict: radio neighbor table with oldest-entry eviction
// Top level: chain of slot cells, sequencer and result register.
// ----------------------------------------------------------------------------
// The table is a ring of TABLE_SLOTS cells that rotates one slot per cycle
// during a search or write turn; slot 0 sits at the head after every full
// turn. A heard report or touch takes one full turn to search (matching
// address and oldest entry) and a second turn to write the chosen slot. A
// prune rotates only the filled part of the ring once, dropping stale heads
// so the kept entries close up in order. One item is in work at a time;
// the result waits in an output register and holds off the next input beat
// until it is taken.
module neighbor_table_lru_evict #(
  parameter int unsigned TABLE_SLOTS = ntle_pkg::DEFAULT_SLOTS
) (
  input logic             clk,
  input logic             rst_n,
  ntle_in_if.sink         in_ch,
  ntle_out_if.source      out_ch,
  ntle_cfg_if.sink        cfg_ch
);

  localparam int unsigned IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [8:0] NSLOTS = 9'(TABLE_SLOTS);
  localparam logic [IW:0] LAST = (IW+1)'(TABLE_SLOTS - 1);

  ntle_pkg::state_t   state_r, state_nxt;
  ntle_pkg::in_beat_t req_r;
  logic [31:0]        ttl_r;
  logic [8:0]         fill_r;
  logic [IW:0]        pos_r;
  logic [8:0]         dropped_r;
  logic               hit_r;
  logic [IW-1:0]      hit_idx_r, old_idx_r, sel_idx;
  logic [31:0]        old_time_r;
  ntle_pkg::out_beat_t res_r;
  logic               res_valid_r;

  logic                shift_all;
  logic [8:0]          win;
  ntle_pkg::entry_t    chain [TABLE_SLOTS];
  ntle_pkg::entry_t    tail_in, head, upd;
  logic                cur_valid, is_sel, stale;
  logic [31:0]         age;

  assign head = chain[0];

  // Active window: whole ring, or only the live entries during a prune.
  assign win = (state_r == ntle_pkg::ST_PRUNE) ? fill_r - dropped_r : NSLOTS;

  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    ntle_pkg::entry_t prev;
    logic             cell_shift, cell_tail;
    if (g == TABLE_SLOTS - 1) begin : g_tail
      assign prev = tail_in;
    end else begin : g_mid
      assign prev = chain[g+1];
    end
    assign cell_shift = shift_all && (9'(g) < win);
    assign cell_tail  = (9'(g) == win - 9'd1);
    ntle_cell u_cell (
      .clk        (clk),
      .shift      (cell_shift),
      .take_tail  (cell_tail),
      .prev_entry (prev),
      .tail_entry (tail_in),
      .entry      (chain[g])
    );
  end

  assign cur_valid = 9'(pos_r) < fill_r;
  assign age       = req_r.time_now - head.last_heard;
  assign stale     = age > ttl_r;
  assign sel_idx   = hit_r ? hit_idx_r : (fill_r < NSLOTS) ? fill_r[IW-1:0] : old_idx_r;
  assign is_sel    = pos_r[IW-1:0] == sel_idx;

  always_comb begin
    ntle_pkg::entry_t base;
    base = head;
    if (!hit_r) begin
      base = '0;
      base.address = req_r.node_address;
    end
    upd = base;
    if (req_r.command == ntle_pkg::CMD_HEARD) begin
      upd.strength    = req_r.signal_strength;
      upd.noise_ratio = req_r.signal_to_noise;
      upd.last_heard  = req_r.time_now;
      upd.packets     = base.packets + 32'd1;
    end else if (req_r.time_now > base.last_heard) begin
      upd.last_heard = req_r.time_now;
    end
  end

  // Head re-enters at the window tail; a dropped head is simply not kept
  // because the window shrinks under it.
  always_comb begin
    tail_in = head;
    if (state_r == ntle_pkg::ST_UPDATE && is_sel) tail_in = upd;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ntle_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = in_ch.data.command[1] ? ntle_pkg::ST_PRUNE : ntle_pkg::ST_SEARCH;
        end
      end
      ntle_pkg::ST_SEARCH: if (pos_r == LAST) state_nxt = ntle_pkg::ST_UPDATE;
      ntle_pkg::ST_UPDATE: if (pos_r == LAST) state_nxt = ntle_pkg::ST_DONE;
      ntle_pkg::ST_PRUNE:  if (pos_r == LAST) state_nxt = ntle_pkg::ST_DONE;
      ntle_pkg::ST_DONE:   if (!res_valid_r || out_ch.ready) state_nxt = ntle_pkg::ST_IDLE;
      default:             state_nxt = ntle_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      ntle_pkg::ST_SEARCH, ntle_pkg::ST_UPDATE: shift_all = 1'b1;
      ntle_pkg::ST_PRUNE: shift_all = cur_valid;
      default: shift_all = 1'b0;
    endcase
  end

  assign in_ch.ready  = (state_r == ntle_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ntle_pkg::ST_IDLE;
      ttl_r       <= ntle_pkg::TTL_RESET;
      fill_r      <= '0;
      res_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) ttl_r <= cfg_ch.data;
      if (res_valid_r && out_ch.ready) res_valid_r <= 1'b0;
      case (state_r)
        ntle_pkg::ST_IDLE: begin
          pos_r <= '0;
          if (in_ch.valid) begin
            req_r      <= in_ch.data;
            hit_r      <= 1'b0;
            old_idx_r  <= '0;
            old_time_r <= '1;
            dropped_r  <= '0;
          end
        end
        ntle_pkg::ST_SEARCH: begin
          if (cur_valid && !hit_r && head.address == req_r.node_address) begin
            hit_r     <= 1'b1;
            hit_idx_r <= pos_r[IW-1:0];
          end
          if (pos_r == '0 || head.last_heard < old_time_r) begin
            old_time_r <= head.last_heard;
            old_idx_r  <= pos_r[IW-1:0];
          end
          pos_r <= (pos_r == LAST) ? '0 : pos_r + 1'b1;
        end
        ntle_pkg::ST_UPDATE: begin
          if (is_sel) begin
            res_r.outcome         <= hit_r ? ntle_pkg::OUT_FOUND :
                                     (fill_r < NSLOTS) ? ntle_pkg::OUT_INSERTED :
                                     ntle_pkg::OUT_EVICTED;
            res_r.slot_index      <= 8'(sel_idx);
            res_r.evicted_address <= (!hit_r && fill_r >= NSLOTS) ? head.address : 16'd0;
            res_r.packet_count    <= upd.packets;
            res_r.last_heard_time <= upd.last_heard;
            res_r.removed_count   <= '0;
            res_r.entries_in_use  <= (!hit_r && fill_r < NSLOTS) ? fill_r + 9'd1 : fill_r;
          end
          pos_r <= (pos_r == LAST) ? '0 : pos_r + 1'b1;
          if (pos_r == LAST) begin
            res_valid_r <= 1'b1;
            if (!hit_r && fill_r < NSLOTS) fill_r <= fill_r + 9'd1;
          end
        end
        ntle_pkg::ST_PRUNE: begin
          if (cur_valid && stale) dropped_r <= dropped_r + 9'd1;
          pos_r <= (pos_r == LAST) ? '0 : pos_r + 1'b1;
          if (pos_r == LAST) begin
            fill_r                <= fill_r - dropped_r - ((cur_valid && stale) ? 9'd1 : 9'd0);
            res_r.outcome         <= ntle_pkg::OUT_PRUNED;
            res_r.slot_index      <= '0;
            res_r.evicted_address <= '0;
            res_r.packet_count    <= '0;
            res_r.last_heard_time <= '0;
            res_r.removed_count   <= dropped_r + ((cur_valid && stale) ? 9'd1 : 9'd0);
            res_r.entries_in_use  <= fill_r - dropped_r - ((cur_valid && stale) ? 9'd1 : 9'd0);
            res_valid_r           <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = res_valid_r;
  assign out_ch.data  = res_r;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: neighbor table lookup, eviction and prune testbench
// A directed set of beats, then random beats, is driven through the input
// channel. A table predictor tracks every accepted beat, and each result
// beat is checked against the oldest prediction. Stalls come at random on
// both channels. The TTL register is rewritten between phases while the
// block is idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SLOTS = ntle_pkg::DEFAULT_SLOTS;
  localparam logic [1:0] CMD_PRUNE = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 600000;

  class neighbor_board;
    logic [15:0]         addr_q[SLOTS];
    logic [31:0]         heard_q[SLOTS];
    logic [31:0]         pkts_q[SLOTS];
    int                  filled;
    logic [31:0]         ttl;
    ntle_pkg::out_beat_t pending[$];
    int                  errors;

    function void clear_table();
      filled = 0;
      ttl = ntle_pkg::TTL_RESET;
      errors = 0;
    endfunction

    function void note_input(ntle_pkg::in_beat_t b);
      ntle_pkg::out_beat_t r;
      int s;
      int w;
      int oldest;
      r = '0;
      if (b.command[1]) begin
        w = 0;
        for (int i = 0; i < filled; i++) begin
          if (b.time_now - heard_q[i] <= ttl) begin
            addr_q[w] = addr_q[i];
            heard_q[w] = heard_q[i];
            pkts_q[w] = pkts_q[i];
            w++;
          end else begin
            r.removed_count++;
          end
        end
        filled = w;
        r.outcome = ntle_pkg::OUT_PRUNED;
      end else begin
        s = -1;
        for (int i = 0; i < filled; i++)
          if (s < 0 && addr_q[i] == b.node_address) s = i;
        if (s >= 0) begin
          r.outcome = ntle_pkg::OUT_FOUND;
        end else begin
          if (filled < SLOTS) begin
            s = filled;
            filled++;
            r.outcome = ntle_pkg::OUT_INSERTED;
          end else begin
            oldest = 0;
            for (int i = 1; i < SLOTS; i++)
              if (heard_q[i] < heard_q[oldest]) oldest = i;
            s = oldest;
            r.evicted_address = addr_q[s];
            r.outcome = ntle_pkg::OUT_EVICTED;
          end
          addr_q[s] = b.node_address;
          heard_q[s] = '0;
          pkts_q[s] = '0;
        end
        if (b.command == ntle_pkg::CMD_HEARD) begin
          heard_q[s] = b.time_now;
          pkts_q[s] = pkts_q[s] + 32'd1;
        end else if (b.time_now > heard_q[s]) begin
          heard_q[s] = b.time_now;
        end
        r.slot_index = 8'(s);
        r.packet_count = pkts_q[s];
        r.last_heard_time = heard_q[s];
      end
      r.entries_in_use = 9'(filled);
      pending.push_back(r);
    endfunction

    function void check_result(ntle_pkg::out_beat_t got);
      ntle_pkg::out_beat_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch: exp o=%0d s=%0d ev=%h p=%0d t=%0d rm=%0d n=%0d",
                   exp.outcome, exp.slot_index, exp.evicted_address, exp.packet_count,
                   exp.last_heard_time, exp.removed_count, exp.entries_in_use);
          $display("                 got o=%0d s=%0d ev=%h p=%0d t=%0d rm=%0d n=%0d",
                   got.outcome, got.slot_index, got.evicted_address, got.packet_count,
                   got.last_heard_time, got.removed_count, got.entries_in_use);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  ntle_in_if  in_ch ();
  ntle_out_if out_ch ();
  ntle_cfg_if cfg_ch ();

  neighbor_table_lru_evict #(.TABLE_SLOTS(SLOTS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  neighbor_board board;
  bit            calm;
  int            cycles = 0;
  logic [31:0]   clock_ms;
  logic [15:0]   addr_pool[12];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 14);
    if (rst_n && out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_beat(logic [1:0] cmd, logic [15:0] addr, logic [31:0] t);
    ntle_pkg::in_beat_t b;
    while (!calm && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    b.command = cmd;
    b.node_address = addr;
    b.signal_strength = 16'($urandom);
    b.signal_to_noise = 8'($urandom);
    b.time_now = t;
    in_ch.valid <= 1'b1;
    in_ch.data <= b;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(b);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (3 * SLOTS) @(posedge clk);
  endtask

  task automatic write_ttl(logic [31:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    board.ttl = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_beat();
    int pick;
    logic [1:0] cmd;
    logic [15:0] addr;
    pick = $urandom_range(99);
    cmd = pick < 60 ? ntle_pkg::CMD_HEARD : pick < 85 ? ntle_pkg::CMD_TOUCH :
          pick < 95 ? CMD_PRUNE : CMD_SPARE;
    addr = $urandom_range(99) < 80 ? addr_pool[$urandom_range(11)]
                                   : 16'($urandom_range(47));
    if ($urandom_range(9) == 0) addr = 16'($urandom);
    if ($urandom_range(19) == 0) clock_ms = $urandom;
    else if ($urandom_range(9) == 0) clock_ms = clock_ms - $urandom_range(500);
    else clock_ms = clock_ms + $urandom_range(2000);
    send_beat(cmd, addr, clock_ms);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    board = new();
    board.clear_table();
    calm = 1'b0;
    clock_ms = 32'd1000;
    for (int i = 0; i < 12; i++) addr_pool[i] = 16'($urandom);
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFF;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, all commands, fill and evict, wrap, tie
    send_beat(ntle_pkg::CMD_HEARD, 16'h0000, 32'd0);
    send_beat(ntle_pkg::CMD_HEARD, 16'hFFFF, 32'hFFFF_FFFF);
    send_beat(ntle_pkg::CMD_HEARD, 16'h0000, 32'd5);
    send_beat(ntle_pkg::CMD_TOUCH, 16'hFFFF, 32'd7);
    send_beat(ntle_pkg::CMD_TOUCH, 16'h1234, 32'd9);
    send_beat(ntle_pkg::CMD_TOUCH, 16'h1234, 32'd3);
    send_beat(CMD_PRUNE, 16'hAAAA, 32'd10);
    send_beat(CMD_SPARE, 16'h5555, 32'h8000_0000);
    for (int i = 0; i < SLOTS + 3; i++)
      send_beat(ntle_pkg::CMD_HEARD, 16'h0100 + 16'(i), 32'd50);
    send_beat(ntle_pkg::CMD_TOUCH, 16'h0200, 32'd0);
    write_ttl(32'd0);
    send_beat(CMD_PRUNE, 16'h0000, 32'd50);
    write_ttl(32'hFFFF_FFFF);
    send_beat(ntle_pkg::CMD_HEARD, 16'h7777, 32'd60);
    send_beat(CMD_PRUNE, 16'h0000, 32'd10);
    write_ttl(32'd1);
    send_beat(CMD_PRUNE, 16'h0000, 32'd62);
    send_beat(CMD_PRUNE, 16'h0000, 32'd62);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_ttl(ntle_pkg::TTL_RESET);
        1: write_ttl(32'd3000);
        2: write_ttl(32'hFFFF_FFFF);
        3: write_ttl(32'd0);
        default: write_ttl($urandom_range(20000));
      endcase
      calm = (phase == 2);
      for (int n = 0; n < 280; n++) random_beat();
    end
    calm = 1'b0;
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
